>>> rtl/span_tracker_macros.svh
// assertion macros for the span tracker
`ifndef SPAN_TRACKER_MACROS_SVH
`define SPAN_TRACKER_MACROS_SVH

`ifndef SYNTH
`define SPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPT_ASSERT(lbl, prop, msg)
`define SPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/spt_pkg.sv
`default_nettype none
package spt_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 11;
  localparam int unsigned TOTAL_W     = 11;
  localparam int unsigned OUT_W       = 1 + TOTAL_W + DATA_W + DATA_W + 1;
  localparam int unsigned OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

endpackage
`default_nettype wire

>>> rtl/span_tracker.sv
`default_nettype none
// Span tracker: each request on s_axis carries one signed 32-bit number. If fewer numbers
// are held than the capacity register allows (saturated at the store depth), the number
// is written to the on-chip store and compared against every number held before it, one
// store read per cycle, to update the closest-pair span; minimum and maximum update at
// once. A number arriving when the store is full is refused with store_full_error set and
// the state unchanged. Every request gives exactly one response on m_axis with the count
// held and both spans. An accepted number is compared against the N numbers held before
// it (N up to 1023) through the single read port of the store; its response is loaded
// into the output register once the scan ends, and a refused number skips the scan. A
// stalled m_axis holds the block in its done state until the output register is free.
// s_axis_tready is high while the block is idle, also while a response still waits in the
// output register. The capacity register may be written only while idle; no clearing
// pass is needed after reset.
`include "span_tracker_macros.svh"

module span_tracker
  import spt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CAP_W-1:0]       cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [DATA_W-1:0]      s_axis_tdata,   // value
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // store_full_error, entry_total, shortest_span, longest_span, spans_valid, zero fill
  output logic [OUT_BYTES_W-1:0]      m_axis_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [DATA_W-1:0]      mem [MAX_ENTRIES];

  logic [1:0]             state_q, state_d;
  logic [CAP_W-1:0]       cap_q;
  logic [CNT_W-1:0]       count_q;
  logic [DATA_W-1:0]      min_q, max_q, best_q, v_q;
  logic [CNT_W-1:0]       scan_end_q, idx_q;
  logic                   rd_vld_q, gap_vld_q, err_q;
  logic [DATA_W-1:0]      rd_data_q, gap_q;
  logic                   out_valid_q;
  logic [OUT_BYTES_W-1:0] out_data_q;

  logic                   accept, full, issue, scan_end, load;
  logic [31:0]            cap_ext, lim32;
  logic [DATA_W:0]        diff;
  logic [DATA_W-1:0]      gap_d;
  logic                   spans_ok;
  logic [DATA_W-1:0]      short_span, long_span;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cap_ext = 32'(cap_q);
  assign lim32   = (cap_ext > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : cap_ext;
  assign full    = (32'(count_q) >= lim32);

  assign issue    = (state_q == ST_SCAN) && (idx_q < scan_end_q);
  assign scan_end = (state_q == ST_SCAN) && !issue && !rd_vld_q && !gap_vld_q;
  assign load     = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // signed difference picks which way to subtract
  assign diff  = {rd_data_q[DATA_W-1], rd_data_q} - {v_q[DATA_W-1], v_q};
  assign gap_d = diff[DATA_W] ? (v_q - rd_data_q) : (rd_data_q - v_q);

  assign spans_ok   = (count_q >= CNT_W'(2));
  assign short_span = spans_ok ? best_q : '1;
  assign long_span  = spans_ok ? (max_q - min_q) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = full ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store: new number goes to the next free slot, reads only touch older slots
  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      mem[count_q[ADDR_W-1:0]] <= s_axis_tdata;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= s_axis_tdata;
    end
    if (rd_vld_q) begin
      gap_q <= gap_d;
    end
    if (load) begin
      out_data_q <= OUT_BYTES_W'({spans_ok, long_span, short_span,
                                  TOTAL_W'(count_q), err_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      min_q       <= {1'b0, {(DATA_W-1){1'b1}}};
      max_q       <= {1'b1, {(DATA_W-1){1'b0}}};
      best_q      <= '1;
      scan_end_q  <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      gap_vld_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= issue;
      gap_vld_q <= rd_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        err_q <= full;
        if (!full) begin
          count_q    <= count_q + CNT_W'(1);
          scan_end_q <= count_q;
          idx_q      <= '0;
          if ($signed(s_axis_tdata) < $signed(min_q)) begin
            min_q <= s_axis_tdata;
          end
          if ($signed(s_axis_tdata) > $signed(max_q)) begin
            max_q <= s_axis_tdata;
          end
        end
      end
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (gap_vld_q && (gap_q < best_q)) begin
        best_q <= gap_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SPT_ASSERT(a_read_below_count, issue |-> (idx_q < count_q), "scan reads an unwritten slot")
  `SPT_ASSERT(a_idle_pipe_empty, s_axis_tready |-> (!rd_vld_q && !gap_vld_q), "scan busy while idle")
  `SPT_ASSERT(a_best_never_grows, 1'b1 |=> (best_q <= $past(best_q)), "closest span grew")
  `SPT_ASSERT(a_refused_keeps_count, (accept && full) |=> $stable(count_q), "refused number counted")
  `SPT_ASSERT_ALWAYS(a_count_bounded, !rst_ni || (count_q <= CNT_W'(MAX_ENTRIES)), "count beyond store depth")

endmodule
`default_nettype wire
